/* hdl/prw_pkg.sv */
// Shared types, constants and helpers of the Prewitt gradient block.
`default_nettype none
package prw_pkg;

  localparam int PIX_W          = 8;
  localparam int CFG_W          = 11;
  localparam int DIFF_W         = 11;
  localparam int CFG_AW         = 3;
  localparam int CFG_DW         = 32;
  localparam int ROW_W          = 11;
  localparam int RES_W          = 21;
  localparam int TOTAL_W        = 2 * CFG_W;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int OUT_DEPTH_DEF  = 4;

  localparam logic [CFG_W-1:0]   WIDTH_RST  = 11'd640;
  localparam logic [CFG_W-1:0]   HEIGHT_RST = 11'd480;
  localparam logic [TOTAL_W-1:0] TOTAL_RST  = 22'd307200;
  localparam logic [ROW_W-1:0]   ROW_SAT    = 11'h7FF;
  localparam logic [PIX_W-1:0]   PIX_MAX    = 8'hFF;

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic [PIX_W-1:0] grad_x;
    logic [PIX_W-1:0] grad_y;
    logic             frame_end;
  } res_t;

  function automatic logic [PIX_W-1:0] clamp_byte(input logic signed [DIFF_W-1:0] v);
    logic [PIX_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed({3'b000, PIX_MAX})) begin
      r = PIX_MAX;
    end else begin
      r = v[PIX_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* hdl/prewitt_gradient_3x3.sv */
// Top level of the streaming 3x3 Prewitt gradient block.
// Usage:
//   Input: in_pixel/in_flush requests in raster order, taken when in_valid is
//   high and in_stall low. After a frame's last pixel send frame_width+1 flush
//   requests for the bottom padding. Output: one request (grad_x, grad_y,
//   frame_end) per pixel, moved when out_valid is high and out_stall low.
//   The result of a pixel is triggered by the request frame_width+1 places
//   later and, once that request is taken, passes stage 1, stage 2 and the queue.
//   Throughput is one request per cycle while in_stall is low, set by the line-store
//   memories: one read and one write of each store per cycle, the write back in the
//   cycle after the read, with forwarding when the same column is hit back to back.
//   A result queue of FIFO_DEPTH entries decouples the two channels; in_stall
//   rises only when queued plus in-flight results would fill it.
//   Configuration over APB: frame_width at 0x0, frame_height at 0x4, zero
//   and out-of-range values clamped to 1..MAX. A write restarts the frame.
//   Reset (rst_n low, synchronous) restarts the frame, sets 640x480 and
//   empties the pipeline; line-store contents are left as they are.
`default_nettype none
module prewitt_gradient_3x3 #(
  parameter int MAX_WIDTH  = prw_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = prw_pkg::MAX_HEIGHT_DEF,
  parameter int FIFO_DEPTH = prw_pkg::OUT_DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [prw_pkg::PIX_W-1:0]   in_pixel,
  input  wire logic                        in_flush,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [prw_pkg::PIX_W-1:0]        out_grad_x,
  output logic [prw_pkg::PIX_W-1:0]        out_grad_y,
  output logic                             out_frame_end,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [prw_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [prw_pkg::CFG_DW-1:0]  pwdata,
  output logic [prw_pkg::CFG_DW-1:0]       prdata,
  output logic                             pready
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam int PW = prw_pkg::PIX_W;
  localparam int SW = PW + 2;

  function automatic logic [prw_pkg::CFG_W-1:0] limit_size(
    input logic [prw_pkg::CFG_W-1:0] v, input int maxv);
    logic [prw_pkg::CFG_W-1:0] r;
    if (v == '0) begin
      r = prw_pkg::CFG_W'(1);
    end else if (32'(v) > maxv) begin
      r = prw_pkg::CFG_W'(maxv);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // configuration
  logic [prw_pkg::CFG_W-1:0]   width_r, width_nxt;
  logic [prw_pkg::CFG_W-1:0]   height_r, height_nxt;
  logic [prw_pkg::TOTAL_W-1:0] total_r;
  logic                        cfg_wr;
  logic                        cfg_idx;

  // frame position
  logic [AW-1:0]               col_r, col_nxt;
  logic [prw_pkg::ROW_W-1:0]   row_r, row_nxt;
  logic [prw_pkg::RES_W-1:0]   res_r, res_nxt;

  // request decode
  logic                        in_acc;
  logic                        c0;
  logic                        emit;
  logic                        last;
  logic                        wrap;
  logic [PW-1:0]               pix_in;
  logic [AW:0]                 col_inc;

  // stage 1
  logic                        s1_v_r;
  logic [AW-1:0]               s1_addr_r;
  logic                        s1_c0_r, s1_ge1_r, s1_ge2_r, s1_emit_r, s1_last_r;
  logic [PW-1:0]               s1_pix_r;
  logic [PW-1:0]               upper_q_r, lower_q_r;
  logic                        fwd_r;
  logic [PW-1:0]               fwd_up_r, fwd_lo_r;
  logic [PW-1:0]               tap_t, tap_m;
  logic [PW-1:0]               win_r   [3][3];
  logic [PW-1:0]               win_nxt [3][3];
  logic [SW-1:0]               sum_l, sum_r, sum_t, sum_b;
  logic signed [prw_pkg::DIFF_W-1:0] gx, gy;

  // stage 2
  logic                        s2_v_r;
  logic                        s2_last_r;
  logic signed [prw_pkg::DIFF_W-1:0] s2_gx_r, s2_gy_r;

  // output queue
  prw_pkg::res_t               push_data;
  prw_pkg::res_t               head;
  logic [CW-1:0]               q_count;
  logic                        pop;

  logic [PW-1:0]               upper_mem [MAX_WIDTH];
  logic [PW-1:0]               lower_mem [MAX_WIDTH];

  // ---------------- configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[2];

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_wr) begin
      unique case (cfg_idx)
        prw_pkg::REG_FRAME_WIDTH:
          width_nxt = limit_size(pwdata[prw_pkg::CFG_W-1:0], MAX_WIDTH);
        prw_pkg::REG_FRAME_HEIGHT:
          height_nxt = limit_size(pwdata[prw_pkg::CFG_W-1:0], MAX_HEIGHT);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      prw_pkg::REG_FRAME_WIDTH:  prdata = prw_pkg::CFG_DW'(width_r);
      prw_pkg::REG_FRAME_HEIGHT: prdata = prw_pkg::CFG_DW'(height_r);
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= prw_pkg::WIDTH_RST;
      height_r <= prw_pkg::HEIGHT_RST;
      total_r  <= prw_pkg::TOTAL_RST;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      if (cfg_wr) begin
        total_r <= prw_pkg::TOTAL_W'(width_nxt) * prw_pkg::TOTAL_W'(height_nxt);
      end
    end
  end

  // ---------------- request decode and frame position
  assign in_stall = (32'(q_count) + 32'(s1_v_r) + 32'(s2_v_r)) >= FIFO_DEPTH;
  assign in_acc   = in_valid && !in_stall;

  assign c0      = (col_r == '0);
  assign pix_in  = (in_flush || row_r >= height_r) ? '0 : in_pixel;
  assign emit    = c0 ? (row_r >= prw_pkg::ROW_W'(2) &&
                         (row_r - prw_pkg::ROW_W'(2)) < height_r)
                      : (row_r != '0 && (row_r - prw_pkg::ROW_W'(1)) < height_r);
  assign last    = emit && ({1'b0, res_r} + prw_pkg::TOTAL_W'(1) == total_r);
  assign col_inc = {1'b0, col_r} + (AW+1)'(1);
  assign wrap    = 32'(col_inc) >= 32'(width_r);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    res_nxt = res_r;
    if (cfg_wr) begin
      col_nxt = '0;
      row_nxt = '0;
      res_nxt = '0;
    end else if (in_acc) begin
      if (last) begin
        col_nxt = '0;
        row_nxt = '0;
        res_nxt = '0;
      end else begin
        col_nxt = wrap ? '0 : col_inc[AW-1:0];
        if (wrap && row_r != prw_pkg::ROW_SAT) begin
          row_nxt = row_r + prw_pkg::ROW_W'(1);
        end
        if (emit) begin
          res_nxt = res_r + prw_pkg::RES_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      res_r  <= '0;
      s1_v_r <= 1'b0;
      fwd_r  <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      res_r  <= res_nxt;
      s1_v_r <= in_acc;
      fwd_r  <= in_acc && s1_v_r && (s1_addr_r == col_r);
      s2_v_r <= s1_v_r && s1_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_addr_r <= col_r;
    s1_c0_r   <= c0;
    s1_ge1_r  <= (row_r != '0);
    s1_ge2_r  <= (row_r >= prw_pkg::ROW_W'(2));
    s1_emit_r <= emit;
    s1_last_r <= last;
    s1_pix_r  <= pix_in;
    fwd_up_r  <= tap_m;
    fwd_lo_r  <= s1_pix_r;
  end

  // ---------------- line stores: read at request, write back in the following cycle
  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      upper_mem[s1_addr_r] <= tap_m;
    end
    upper_q_r <= upper_mem[col_r];
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      lower_mem[s1_addr_r] <= s1_pix_r;
    end
    lower_q_r <= lower_mem[col_r];
  end

  // ---------------- stage 1: window update and sums
  assign tap_t = s1_ge2_r ? (fwd_r ? fwd_up_r : upper_q_r) : '0;
  assign tap_m = s1_ge1_r ? (fwd_r ? fwd_lo_r : lower_q_r) : '0;

  always_comb begin
    logic [PW-1:0] nt, nm, nb;
    nt = s1_c0_r ? '0 : tap_t;
    nm = s1_c0_r ? '0 : tap_m;
    nb = s1_c0_r ? '0 : s1_pix_r;
    sum_l = SW'(win_r[0][1]) + SW'(win_r[1][1]) + SW'(win_r[2][1]);
    sum_r = SW'(nt) + SW'(nm) + SW'(nb);
    sum_t = SW'(win_r[0][1]) + SW'(win_r[0][2]) + SW'(nt);
    sum_b = SW'(win_r[2][1]) + SW'(win_r[2][2]) + SW'(nb);
    gx = $signed({1'b0, sum_l}) - $signed({1'b0, sum_r});
    gy = $signed({1'b0, sum_t}) - $signed({1'b0, sum_b});
    for (int r = 0; r < 3; r++) begin
      win_nxt[r][0] = s1_c0_r ? '0 : win_r[r][1];
      win_nxt[r][1] = s1_c0_r ? '0 : win_r[r][2];
    end
    win_nxt[0][2] = tap_t;
    win_nxt[1][2] = tap_m;
    win_nxt[2][2] = s1_pix_r;
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      win_r <= win_nxt;
    end
    s2_gx_r   <= gx;
    s2_gy_r   <= gy;
    s2_last_r <= s1_last_r;
  end

  // ---------------- stage 2: clamp into the result queue
  always_comb begin
    push_data.grad_x    = prw_pkg::clamp_byte(s2_gx_r);
    push_data.grad_y    = prw_pkg::clamp_byte(s2_gy_r);
    push_data.frame_end = s2_last_r;
  end

  assign pop = out_valid && !out_stall;

  prw_out_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s2_v_r),
    .push_data (push_data),
    .pop       (pop),
    .not_empty (out_valid),
    .head      (head),
    .count     (q_count)
  );

  assign out_grad_x    = head.grad_x;
  assign out_grad_y    = head.grad_y;
  assign out_frame_end = head.frame_end;

  // ---------------- checks
  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(q_count) + 32'(s1_v_r) + 32'(s2_v_r)) <= FIFO_DEPTH)
    else $error("result queue overcommitted");

  a_fwd_needs_s1: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> s1_v_r)
    else $error("forward flag without a request in stage 1");

  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    32'(col_r) < 32'(width_r))
    else $error("column beyond frame width");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |-> (32'(q_count) < FIFO_DEPTH))
    else $error("push into a full result queue");

endmodule
`default_nettype wire

/* hdl/prw_out_fifo.sv */
// Result queue between the gradient pipeline and the output channel.
`default_nettype none
module prw_out_fifo #(
  parameter int DEPTH = prw_pkg::OUT_DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       push,
  input  wire prw_pkg::res_t              push_data,
  input  wire logic                       pop,
  output logic                            not_empty,
  output prw_pkg::res_t                   head,
  output logic [$clog2(DEPTH+1)-1:0]      count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  prw_pkg::res_t    store_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == DEPTH - 1) ? '0 : PW'(32'(wr_ptr_r) + 1);
    end
    if (pop) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == DEPTH - 1) ? '0 : PW'(32'(rd_ptr_r) + 1);
    end
    if (push && !pop) begin
      count_nxt = CW'(32'(count_r) + 1);
    end else if (pop && !push) begin
      count_nxt = CW'(32'(count_r) - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_data;
    end
  end

  assign not_empty = (count_r != '0);
  assign head      = store_r[rd_ptr_r];
  assign count     = count_r;

endmodule
`default_nettype wire

/* test/prewitt_gradient_3x3_tb.sv */
// Self-checking testbench for the streaming 3x3 Prewitt gradient block.
`timescale 1ns / 1ps
module prewitt_gradient_3x3_tb;

  localparam int MAX_COLS    = prw_pkg::MAX_WIDTH_DEF;
  localparam int MAX_ROWS    = prw_pkg::MAX_HEIGHT_DEF;
  localparam int SETTLE      = 12;
  localparam int QUIET_LIMIT = 4000;
  localparam int LONG_HOLD   = 300;

  typedef enum {ROW_PIXEL, ROW_WIDTH, ROW_HEIGHT} row_kind_t;

  typedef struct {
    row_kind_t                 kind;
    logic [31:0]               value;
    logic [prw_pkg::PIX_W-1:0] pix;
    logic                      flush;
    bit                        typed;
    prw_pkg::res_t             res;
  } row_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [prw_pkg::PIX_W-1:0] in_pixel = '0;
  logic in_flush = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [prw_pkg::PIX_W-1:0] out_grad_x;
  logic [prw_pkg::PIX_W-1:0] out_grad_y;
  logic out_frame_end;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [prw_pkg::CFG_AW-1:0] paddr = '0;
  logic [prw_pkg::CFG_DW-1:0] pwdata = '0;
  logic [prw_pkg::CFG_DW-1:0] prdata;
  logic pready;

  // known result for the request currently offered, if any
  bit            typed_valid = 1'b0;
  prw_pkg::res_t typed_res = '0;

  prewitt_gradient_3x3 dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_pixel(in_pixel), .in_flush(in_flush),
    .out_valid(out_valid), .out_stall(out_stall), .out_grad_x(out_grad_x),
    .out_grad_y(out_grad_y), .out_frame_end(out_frame_end),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  // gradient predictor state
  logic [prw_pkg::PIX_W-1:0] line_up1 [0:MAX_COLS-1];
  logic [prw_pkg::PIX_W-1:0] line_up2 [0:MAX_COLS-1];
  logic [prw_pkg::PIX_W-1:0] win [0:2][0:2];
  int unsigned col_pos = 0;
  int unsigned row_pos = 0;
  int unsigned pix_done = 0;
  int unsigned cur_width = 640;
  int unsigned cur_height = 480;

  prw_pkg::res_t pending_grads [$];
  row_t script [$];
  int   err_count = 0;
  int   res_count = 0;
  int   quiet = 0;
  int   burst_left = 0;

  function automatic void clear_window();
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        win[r][c] = '0;
  endfunction

  function automatic void restart_frame();
    clear_window();
    col_pos = 0;
    row_pos = 0;
    pix_done = 0;
  endfunction

  function automatic int unsigned size_of(input logic [31:0] v, input int unsigned maxv);
    int unsigned s;
    s = 32'(v[prw_pkg::CFG_W-1:0]);
    if (s == 0) s = 1;
    if (s > maxv) s = maxv;
    return s;
  endfunction

  function automatic logic [prw_pkg::PIX_W-1:0] sat_byte(input int v);
    if (v > 255) return 8'hFF;
    if (v < 0) return 8'h00;
    return v[prw_pkg::PIX_W-1:0];
  endfunction

  function automatic void shift_column(input logic [prw_pkg::PIX_W-1:0] t, m, b);
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = t;
    win[1][2] = m;
    win[2][2] = b;
  endfunction

  function automatic prw_pkg::res_t window_grads();
    int left, right, top, bottom;
    prw_pkg::res_t r;
    left = 0;
    right = 0;
    top = 0;
    bottom = 0;
    for (int i = 0; i < 3; i++) begin
      left += win[i][0];
      right += win[i][2];
      top += win[0][i];
      bottom += win[2][i];
    end
    r.grad_x = sat_byte(left - right);
    r.grad_y = sat_byte(top - bottom);
    r.frame_end = 1'b0;
    return r;
  endfunction

  function automatic bit next_gradient(input logic [prw_pkg::PIX_W-1:0] pix,
                                       input logic flush, output prw_pkg::res_t r);
    int unsigned c;
    logic [prw_pkg::PIX_W-1:0] v, t, m;
    bit hit;
    c = col_pos % MAX_COLS;
    v = (flush || row_pos >= cur_height) ? 8'd0 : pix;
    t = (row_pos >= 2) ? line_up2[c] : 8'd0;
    m = (row_pos >= 1) ? line_up1[c] : 8'd0;
    line_up2[c] = m;
    line_up1[c] = v;
    hit = 1'b0;
    r = '0;
    if (c == 0) begin
      // right padding closes the last pixel two rows up
      shift_column(8'd0, 8'd0, 8'd0);
      if (row_pos >= 2 && row_pos - 2 < cur_height) begin
        r = window_grads();
        hit = 1'b1;
      end
      clear_window();
      win[0][2] = t;
      win[1][2] = m;
      win[2][2] = v;
    end else begin
      shift_column(t, m, v);
      if (row_pos >= 1 && row_pos - 1 < cur_height) begin
        r = window_grads();
        hit = 1'b1;
      end
    end
    col_pos = c + 1;
    if (col_pos >= cur_width) begin
      col_pos = 0;
      if (row_pos < 'h7FF) row_pos++;
    end
    if (hit) begin
      r.frame_end = (pix_done + 1 == cur_width * cur_height);
      pix_done = (pix_done + 1) & 'h1F_FFFF;
      if (r.frame_end) restart_frame();
    end
    return hit;
  endfunction

  function automatic row_t row(input row_kind_t kind, input logic [31:0] value,
                               input logic [prw_pkg::PIX_W-1:0] pix, input logic flush,
                               input bit typed, input logic [prw_pkg::PIX_W-1:0] gx, gy,
                               input logic fe);
    row_t e;
    e.kind = kind;
    e.value = value;
    e.pix = pix;
    e.flush = flush;
    e.typed = typed;
    e.res.grad_x = gx;
    e.res.grad_y = gy;
    e.res.frame_end = fe;
    return e;
  endfunction

  function automatic logic [31:0] with_noise(input int unsigned v);
    if ($urandom_range(0, 3) == 0) return ($urandom() & 32'hFFFF_F800) | v;
    return v;
  endfunction

  function automatic logic [prw_pkg::PIX_W-1:0] pick_pixel();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return prw_pkg::PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_item(input logic [prw_pkg::PIX_W-1:0] p, input logic f,
                           input bit ty, input prw_pkg::res_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_pixel <= p;
    in_flush <= f;
    typed_valid <= ty;
    typed_res <= r;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_grads.size() != 0) @(posedge clk);
  endtask

  task automatic settle();
    hold_until_drained();
    repeat (SETTLE) @(posedge clk);
  endtask

  // write one register, then read it back and check the clamped value
  task automatic write_reg(input logic idx, input logic [31:0] val);
    int unsigned want;
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == prw_pkg::REG_FRAME_WIDTH) cur_width = size_of(val, MAX_COLS);
    else cur_height = size_of(val, MAX_ROWS);
    restart_frame();
    want = (idx == prw_pkg::REG_FRAME_WIDTH) ? cur_width : cur_height;
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== prw_pkg::CFG_DW'(want)) begin
      if (err_count < 10)
        $display("[%0t] register %0d read back exp/got: %0d/%0d",
                 $realtime, idx, want, prdata);
      err_count++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // one frame plus its bottom padding; a broken frame stops part way
  task automatic send_frame(input bit broken, output int n);
    int total;
    logic f;
    total = cur_width * cur_height + cur_width + 1;
    if (broken) total = $urandom_range(1, total - 1);
    for (int k = 0; k < total; k++) begin
      if (k < cur_width * cur_height) f = ($urandom_range(0, 19) == 0);
      else f = ($urandom_range(0, 5) != 0);
      push_item(pick_pixel(), f, 1'b0, '0);
    end
    n = total;
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    prw_pkg::res_t got, want, pred;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got.grad_x = out_grad_x;
        got.grad_y = out_grad_y;
        got.frame_end = out_frame_end;
        res_count++;
        if (pending_grads.size() == 0) begin
          if (err_count < 10)
            $display("[%0t] unexpected request: grad_x %0d grad_y %0d frame_end %0d",
                     $realtime, got.grad_x, got.grad_y, got.frame_end);
          err_count++;
        end else begin
          want = pending_grads.pop_front();
          if (got.grad_x !== want.grad_x || got.grad_y !== want.grad_y ||
              got.frame_end !== want.frame_end) begin
            if (err_count < 10)
              $display("[%0t] mismatch exp/got: grad_x %0d/%0d grad_y %0d/%0d fe %0d/%0d",
                       $realtime, want.grad_x, got.grad_x, want.grad_y, got.grad_y,
                       want.frame_end, got.frame_end);
            err_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (next_gradient(in_pixel, in_flush, pred))
          pending_grads.push_back(typed_valid ? typed_res : pred);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
      quiet <= 0;
    else if (quiet >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else
      quiet <= quiet + 1;
  end

  // receiver: stall pattern of its own, plus one long hold-off at a frame start
  initial begin
    int mode, span, hold_left;
    bit held_once;
    mode = 0;
    span = 0;
    hold_left = 0;
    held_once = 1'b0;
    forever begin
      @(negedge clk);
      if (span == 0) begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(20, 120);
      end
      span--;
      if (!held_once && res_count >= 20 && in_valid && pix_done == 0 &&
          cur_width * cur_height >= 24) begin
        hold_left = LONG_HOLD;
        held_once = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= (span % 5 < 2);
        endcase
      end
    end
  end

  initial begin
    int small_items, frames, n;
    bit wide_done, tall_done, big, paused;
    logic [31:0] wv, hv;
    small_items = 0;
    wide_done = 1'b0;
    tall_done = 1'b0;
    paused = 1'b0;

    // default 640x480 after reset: nothing comes out this early
    script.push_back(row(ROW_PIXEL, 0, 8'h00, 1'b0, 1'b0, 0, 0, 0));
    script.push_back(row(ROW_PIXEL, 0, 8'hFF, 1'b0, 1'b0, 0, 0, 0));
    // 3x3 all white: edges clamp to 255, inner and top-left edges to 0
    script.push_back(row(ROW_WIDTH, 3, 0, 1'b0, 1'b0, 0, 0, 0));
    script.push_back(row(ROW_HEIGHT, 3, 0, 1'b0, 1'b0, 0, 0, 0));
    repeat (4) script.push_back(row(ROW_PIXEL, 0, 8'hFF, 1'b0, 1'b0, 0, 0, 0));
    script.push_back(row(ROW_PIXEL, 0, 8'hFF, 1'b0, 1'b1, 8'd0, 8'd0, 1'b0));
    script.push_back(row(ROW_PIXEL, 0, 8'hFF, 1'b0, 1'b1, 8'd0, 8'd0, 1'b0));
    script.push_back(row(ROW_PIXEL, 0, 8'hFF, 1'b0, 1'b1, 8'd255, 8'd0, 1'b0));
    script.push_back(row(ROW_PIXEL, 0, 8'hFF, 1'b0, 1'b1, 8'd0, 8'd0, 1'b0));
    script.push_back(row(ROW_PIXEL, 0, 8'hFF, 1'b0, 1'b1, 8'd0, 8'd0, 1'b0));
    script.push_back(row(ROW_PIXEL, 0, 8'h00, 1'b1, 1'b1, 8'd255, 8'd0, 1'b0));
    script.push_back(row(ROW_PIXEL, 0, 8'h00, 1'b1, 1'b1, 8'd0, 8'd255, 1'b0));
    script.push_back(row(ROW_PIXEL, 0, 8'h00, 1'b1, 1'b1, 8'd0, 8'd255, 1'b0));
    script.push_back(row(ROW_PIXEL, 0, 8'h00, 1'b1, 1'b1, 8'd255, 8'd255, 1'b1));
    // zero sizes act as 1x1; a plain pixel in the padding still reads as zero
    script.push_back(row(ROW_WIDTH, 0, 0, 1'b0, 1'b0, 0, 0, 0));
    script.push_back(row(ROW_HEIGHT, 0, 0, 1'b0, 1'b0, 0, 0, 0));
    script.push_back(row(ROW_PIXEL, 0, 8'd200, 1'b0, 1'b0, 0, 0, 0));
    script.push_back(row(ROW_PIXEL, 0, 8'd77, 1'b0, 1'b0, 0, 0, 0));
    script.push_back(row(ROW_PIXEL, 0, 8'h00, 1'b1, 1'b1, 8'd0, 8'd0, 1'b1));
    // 2x2 with an early flush and a pixel in the padding
    script.push_back(row(ROW_WIDTH, 2, 0, 1'b0, 1'b0, 0, 0, 0));
    script.push_back(row(ROW_HEIGHT, 2, 0, 1'b0, 1'b0, 0, 0, 0));
    script.push_back(row(ROW_PIXEL, 0, 8'h00, 1'b0, 1'b0, 0, 0, 0));
    script.push_back(row(ROW_PIXEL, 0, 8'hA5, 1'b1, 1'b0, 0, 0, 0));
    script.push_back(row(ROW_PIXEL, 0, 8'hFF, 1'b0, 1'b0, 0, 0, 0));
    script.push_back(row(ROW_PIXEL, 0, 8'h80, 1'b0, 1'b0, 0, 0, 0));
    script.push_back(row(ROW_PIXEL, 0, 8'd99, 1'b0, 1'b0, 0, 0, 0));
    script.push_back(row(ROW_PIXEL, 0, 8'h00, 1'b1, 1'b0, 0, 0, 0));
    script.push_back(row(ROW_PIXEL, 0, 8'h00, 1'b1, 1'b0, 0, 0, 0));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      if (script[i].kind == ROW_PIXEL) begin
        push_item(script[i].pix, script[i].flush, script[i].typed, script[i].res);
      end else begin
        settle();
        write_reg(script[i].kind == ROW_WIDTH ? prw_pkg::REG_FRAME_WIDTH
                                              : prw_pkg::REG_FRAME_HEIGHT,
                  script[i].value);
      end
    end

    // oversized settings are checked by read-back only
    while (small_items < 420 || !wide_done || !tall_done) begin
      big = 1'b1;
      if (!wide_done && small_items >= 150) begin
        wv = 2047;
        hv = 1;
        wide_done = 1'b1;
      end else if (!tall_done && small_items >= 300) begin
        wv = 1;
        hv = 2047;
        tall_done = 1'b1;
      end else begin
        big = 1'b0;
        wv = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
        hv = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
      end
      settle();
      write_reg(prw_pkg::REG_FRAME_WIDTH, with_noise(wv));
      write_reg(prw_pkg::REG_FRAME_HEIGHT, with_noise(hv));
      frames = big ? 0 : $urandom_range(1, 3);
      for (int f = 0; f < frames; f++) begin
        send_frame(f == frames - 1 && $urandom_range(0, 5) == 0, n);
        small_items += n;
        if (!paused || $urandom_range(0, 7) == 0) begin
          hold_until_drained();
          paused = 1'b1;
        end
      end
    end

    settle();
    repeat (SETTLE) @(posedge clk);
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
